// File: rtl/core/qlm_pkg.sv
// qlm_pkg: shared types, widths, register codes and the PAM level table
// of the QAM max-log LLR demapper. Depends on nothing.
`timescale 1ns / 1ps
package qlm_pkg;

  localparam int SAMPLE_W      = 16;  // Q3.12 sample width
  localparam int LLR_W         = 16;  // Q11.4 result width
  localparam int SCALE_W       = 16;  // Q8.8 scale width
  localparam int MOD_W         = 2;
  localparam int NB_W          = 3;   // bits per axis, 1..4
  localparam int LEVEL_W       = 14;  // signed Q1.12 level
  localparam int NUM_LLR       = 8;
  localparam int MAX_BITS_DEF  = 4;
  localparam int TAB_ROWS      = 4;
  localparam int TAB_COLS      = 16;
  localparam int TAB_COL_W     = 4;

  // |sample - level| fits 16 bits unsigned: 32768 + 4712 < 65536
  localparam int DIST_W        = SAMPLE_W + 1;
  localparam int MAG_W         = SAMPLE_W;
  // (m1 - m0) * (m1 + m0)
  localparam int PROD_W        = 2 * MAG_W + 1;
  localparam int ROUND_SHIFT   = 28;  // Q.32 down to Q.4

  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MOD_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LLR_SCALE = 1'd1;
  localparam logic [MOD_W-1:0]     MOD_ORDER_RST     = 2'd0;
  localparam logic [SCALE_W-1:0]   LLR_SCALE_RST     = 16'd512;

  localparam logic signed [LLR_W-1:0] LLR_POS_MAX = 16'sh7fff;
  localparam logic signed [LLR_W-1:0] LLR_NEG_MAX = 16'sh8000;

  // Normalized PAM levels per bits-per-axis, indexed by bit pattern, b0 as MSB
  localparam logic signed [LEVEL_W-1:0] LEVEL_TAB [TAB_ROWS][TAB_COLS] = '{
    '{14'sd2896, -14'sd2896, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0,
      14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0},
    '{14'sd1295, 14'sd3886, -14'sd1295, -14'sd3886, 14'sd0, 14'sd0, 14'sd0, 14'sd0,
      14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0},
    '{14'sd1896, 14'sd632, 14'sd3160, 14'sd4424,
      -14'sd1896, -14'sd632, -14'sd3160, -14'sd4424,
      14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0},
    '{14'sd1571, 14'sd2199, 14'sd942, 14'sd314, 14'sd3456, 14'sd2827, 14'sd4084, 14'sd4712,
      -14'sd1571, -14'sd2199, -14'sd942, -14'sd314,
      -14'sd3456, -14'sd2827, -14'sd4084, -14'sd4712}
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
  } in_beat_t;

  typedef struct packed {
    logic signed [LLR_W-1:0] llr_0;
    logic signed [LLR_W-1:0] llr_1;
    logic signed [LLR_W-1:0] llr_2;
    logic signed [LLR_W-1:0] llr_3;
    logic signed [LLR_W-1:0] llr_4;
    logic signed [LLR_W-1:0] llr_5;
    logic signed [LLR_W-1:0] llr_6;
    logic signed [LLR_W-1:0] llr_7;
  } out_beat_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_en_t;

endpackage

// File: rtl/core/qlm_dist_stage.sv
// qlm_dist_stage: stage 1, distance magnitude of one axis sample to every level.
// Depends on qlm_pkg.
`timescale 1ns / 1ps
module qlm_dist_stage #(
  parameter int MAX_BITS = qlm_pkg::MAX_BITS_DEF
) (
  input  logic                                  clk,
  input  qlm_pkg::pipe_en_t                     en,
  input  logic [qlm_pkg::NB_W-1:0]              nb,
  input  logic signed [qlm_pkg::SAMPLE_W-1:0]   sample,
  output logic [qlm_pkg::MAG_W-1:0]             mag_r [2**MAX_BITS]
);

  localparam int LV = 2**MAX_BITS;

  logic [1:0]                        row;
  logic [qlm_pkg::MAG_W-1:0]         mag_nxt [LV];

  assign row = 2'(nb - 3'd1);

  always_comb begin
    logic signed [qlm_pkg::LEVEL_W-1:0] lvl;
    logic signed [qlm_pkg::DIST_W-1:0]  d;
    for (int j = 0; j < LV; j++) begin
      lvl = qlm_pkg::LEVEL_TAB[row][qlm_pkg::TAB_COL_W'(j)];
      d   = qlm_pkg::DIST_W'(sample) - qlm_pkg::DIST_W'(lvl);
      mag_nxt[j] = d[qlm_pkg::DIST_W-1] ? qlm_pkg::MAG_W'(-d) : qlm_pkg::MAG_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag_r <= mag_nxt;
    end
  end

endmodule

// File: rtl/core/qlm_min_stage.sv
// qlm_min_stage: stage 2, nearest-level distance per bit among levels with bit 0 / bit 1.
// Depends on qlm_pkg.
`timescale 1ns / 1ps
module qlm_min_stage #(
  parameter int MAX_BITS = qlm_pkg::MAX_BITS_DEF
) (
  input  logic                        clk,
  input  qlm_pkg::pipe_en_t           en,
  input  logic [qlm_pkg::NB_W-1:0]    nb,
  input  logic [qlm_pkg::MAG_W-1:0]   mag [2**MAX_BITS],
  output logic [qlm_pkg::MAG_W-1:0]   m0_r [MAX_BITS],
  output logic [qlm_pkg::MAG_W-1:0]   m1_r [MAX_BITS]
);

  localparam int LV = 2**MAX_BITS;
  localparam int JX = MAX_BITS + 1;

  logic [qlm_pkg::MAG_W-1:0] m0_nxt [MAX_BITS];
  logic [qlm_pkg::MAG_W-1:0] m1_nxt [MAX_BITS];

  for (genvar k = 0; k < MAX_BITS; k++) begin : g_bit
    always_comb begin
      logic [qlm_pkg::MAG_W-1:0] t0 [LV];
      logic [qlm_pkg::MAG_W-1:0] t1 [LV];
      logic [qlm_pkg::NB_W-1:0]  pos;
      logic [JX-1:0]             jx;
      logic [JX-1:0]             sh;
      logic                      in_rng;
      pos = qlm_pkg::NB_W'(nb - 3'd1 - qlm_pkg::NB_W'(k));
      for (int j = 0; j < LV; j++) begin
        jx     = JX'(j);
        sh     = jx >> pos;
        in_rng = ((jx >> nb) == '0);
        t0[j]  = (in_rng && !sh[0]) ? mag[j] : '1;
        t1[j]  = (in_rng &&  sh[0]) ? mag[j] : '1;
      end
      // min tree, result lands in entry 0
      for (int s = 1; s < LV; s = s * 2) begin
        for (int i = 0; i + s < LV; i = i + 2 * s) begin
          if (t0[i + s] < t0[i]) t0[i] = t0[i + s];
          if (t1[i + s] < t1[i]) t1[i] = t1[i + s];
        end
      end
      m0_nxt[k] = t0[0];
      m1_nxt[k] = t1[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      m0_r <= m0_nxt;
      m1_r <= m1_nxt;
    end
  end

endmodule

// File: rtl/core/qlm_llr_unit.sv
// qlm_llr_unit: stages 3..6 for one LLR: distance difference, product, scaling,
// rounding to Q11.4 and saturation. Depends on qlm_pkg.
`timescale 1ns / 1ps
module qlm_llr_unit (
  input  logic                                clk,
  input  qlm_pkg::pipe_en_t                   en,
  input  logic                                used,
  input  logic [qlm_pkg::MAG_W-1:0]           m0,
  input  logic [qlm_pkg::MAG_W-1:0]           m1,
  input  logic [qlm_pkg::SCALE_W-1:0]         scale,
  output logic signed [qlm_pkg::LLR_W-1:0]    llr_r
);

  localparam int MW   = qlm_pkg::PROD_W;
  localparam int H    = (MW + 1) / 2;
  localparam int SUMW = MW + qlm_pkg::SCALE_W + 1;
  localparam int QW   = SUMW - qlm_pkg::ROUND_SHIFT;
  localparam logic [SUMW-1:0] RND = SUMW'(1) << (qlm_pkg::ROUND_SHIFT - 1);

  // stage 3
  logic [qlm_pkg::MAG_W-1:0]      ad_r;
  logic [qlm_pkg::MAG_W:0]        sm_r;
  logic                           neg3_r, used3_r;
  // stage 4
  logic [MW-1:0]                  prod_r;
  logic                           neg4_r, used4_r;
  // stage 5
  logic [H+qlm_pkg::SCALE_W-1:0]       lo_r;
  logic [MW-H+qlm_pkg::SCALE_W-1:0]    hi_r;
  logic                                neg5_r, used5_r;

  logic                           neg3_nxt;
  logic [SUMW-1:0]                sum;
  logic [QW-1:0]                  q;
  logic signed [qlm_pkg::LLR_W-1:0] llr_nxt;

  assign neg3_nxt = (m1 < m0);

  // |m1^2 - m0^2| = |m1 - m0| * (m1 + m0); sign of the LLR is neg
  always_ff @(posedge clk) begin
    if (en.s3) begin
      ad_r    <= neg3_nxt ? (m0 - m1) : (m1 - m0);
      sm_r    <= (qlm_pkg::MAG_W+1)'(m0) + (qlm_pkg::MAG_W+1)'(m1);
      neg3_r  <= neg3_nxt;
      used3_r <= used;
    end
    if (en.s4) begin
      prod_r  <= MW'(ad_r) * MW'(sm_r);
      neg4_r  <= neg3_r;
      used4_r <= used3_r;
    end
    // product with scale split in two partial products
    if (en.s5) begin
      lo_r    <= (H+qlm_pkg::SCALE_W)'(prod_r[H-1:0]) * (H+qlm_pkg::SCALE_W)'(scale);
      hi_r    <= (MW-H+qlm_pkg::SCALE_W)'(prod_r[MW-1:H])
                 * (MW-H+qlm_pkg::SCALE_W)'(scale);
      neg5_r  <= neg4_r;
      used5_r <= used4_r;
    end
    if (en.s6) begin
      llr_r   <= llr_nxt;
    end
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    sum = SUMW'(lo_r) + (SUMW'(hi_r) << H) + RND;
    q   = sum[SUMW-1:qlm_pkg::ROUND_SHIFT];
    if (!used5_r) begin
      llr_nxt = '0;
    end else if (neg5_r) begin
      if (q >= QW'(32768)) llr_nxt = qlm_pkg::LLR_NEG_MAX;
      else                 llr_nxt = $signed(16'd0 - q[qlm_pkg::LLR_W-1:0]);
    end else begin
      if (q >= QW'(32767)) llr_nxt = qlm_pkg::LLR_POS_MAX;
      else                 llr_nxt = $signed(q[qlm_pkg::LLR_W-1:0]);
    end
  end

endmodule

// File: rtl/core/qam_maxlog_llr_demapper.sv
// qam_maxlog_llr_demapper: top level of the max-log QAM soft demapper
// (QPSK..256QAM, separable I/Q). Depends on qlm_pkg, qlm_dist_stage,
// qlm_min_stage and qlm_llr_unit.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  in_      | in_valid / in_ready      | in_data  (sample_i, sample_q Q3.12)
//  out_     | out_valid / out_ready    | out_data (llr_0..llr_7 Q11.4)
//  cfg_     | cfg_we (no wait)         | cfg_idx, cfg_wdata
//
// One beat per clock sustained while out_ready holds; a beat passes the stage chain
// distance -> nearest-level min -> difference -> square product -> scale
// partial products -> round/saturate.
// Reset (synchronous, rst_n low) empties the pipe and loads mod_order = QPSK,
// llr_scale = 2.0. No clearing pass.
// Stalls: each full stage holds while the one after it is full and stalled, so
// bubbles close up and in_ready drops only when all six stages are full.
`timescale 1ns / 1ps
module qam_maxlog_llr_demapper #(
  parameter int MAX_BITS_PER_AXIS = qlm_pkg::MAX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  qlm_pkg::in_beat_t                  in_data,
  // LLR output
  output logic                               out_valid,
  input  logic                               out_ready,
  output qlm_pkg::out_beat_t                 out_data,
  // register writes
  input  logic                               cfg_we,
  input  logic [qlm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [qlm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NSTG = 6;
  localparam int LV   = 2**MAX_BITS_PER_AXIS;
  localparam int MB   = MAX_BITS_PER_AXIS;

  // ---------------- configuration registers ----------------
  logic [qlm_pkg::MOD_W-1:0]   mod_order_r;
  logic [qlm_pkg::SCALE_W-1:0] llr_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_order_r <= qlm_pkg::MOD_ORDER_RST;
      llr_scale_r <= qlm_pkg::LLR_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qlm_pkg::CFG_IDX_MOD_ORDER: mod_order_r <= cfg_wdata[qlm_pkg::MOD_W-1:0];
        qlm_pkg::CFG_IDX_LLR_SCALE: llr_scale_r <= cfg_wdata[qlm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // bits per axis, capped by the build-time maximum
  logic [qlm_pkg::NB_W-1:0] nb_in;
  always_comb begin
    nb_in = qlm_pkg::NB_W'(mod_order_r) + 3'd1;
    if (nb_in > qlm_pkg::NB_W'(MB)) nb_in = qlm_pkg::NB_W'(MB);
  end

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG:0]   rdy;      // rdy[i]: stage i may load; rdy[NSTG] is out_ready
  qlm_pkg::pipe_en_t en;

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i + 1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i - 1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en.s1     = rdy[0];
  assign en.s2     = rdy[1];
  assign en.s3     = rdy[2];
  assign en.s4     = rdy[3];
  assign en.s5     = rdy[4];
  assign en.s6     = rdy[5];
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // side data traveling with the beat: bits per axis and scale
  logic [qlm_pkg::NB_W-1:0]    nb_s1_r, nb_s2_r;
  logic [qlm_pkg::SCALE_W-1:0] scale_s1_r, scale_s2_r, scale_s3_r, scale_s4_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      nb_s1_r    <= nb_in;
      scale_s1_r <= llr_scale_r;
    end
    if (en.s2) begin
      nb_s2_r    <= nb_s1_r;
      scale_s2_r <= scale_s1_r;
    end
    if (en.s3) scale_s3_r <= scale_s2_r;
    if (en.s4) scale_s4_r <= scale_s3_r;
  end

  // ---------------- datapath, I and Q axes ----------------
  logic [qlm_pkg::MAG_W-1:0] mag_i [LV];
  logic [qlm_pkg::MAG_W-1:0] mag_q [LV];
  logic [qlm_pkg::MAG_W-1:0] m0_i [MB];
  logic [qlm_pkg::MAG_W-1:0] m1_i [MB];
  logic [qlm_pkg::MAG_W-1:0] m0_q [MB];
  logic [qlm_pkg::MAG_W-1:0] m1_q [MB];
  logic signed [qlm_pkg::LLR_W-1:0] llr_w [qlm_pkg::NUM_LLR];

  qlm_dist_stage #(.MAX_BITS(MB)) u_dist_i (
    .clk(clk), .en(en), .nb(nb_in), .sample(in_data.sample_i), .mag_r(mag_i)
  );
  qlm_dist_stage #(.MAX_BITS(MB)) u_dist_q (
    .clk(clk), .en(en), .nb(nb_in), .sample(in_data.sample_q), .mag_r(mag_q)
  );

  qlm_min_stage #(.MAX_BITS(MB)) u_min_i (
    .clk(clk), .en(en), .nb(nb_s1_r), .mag(mag_i), .m0_r(m0_i), .m1_r(m1_i)
  );
  qlm_min_stage #(.MAX_BITS(MB)) u_min_q (
    .clk(clk), .en(en), .nb(nb_s1_r), .mag(mag_q), .m0_r(m0_q), .m1_r(m1_q)
  );

  // one scaling unit per LLR; even slots I, odd slots Q
  for (genvar k = 0; k < qlm_pkg::NUM_LLR / 2; k++) begin : g_llr
    if (k < MB) begin : g_used
      logic used;
      assign used = (qlm_pkg::NB_W'(k) < nb_s2_r);
      qlm_llr_unit u_llr_i (
        .clk(clk), .en(en), .used(used), .m0(m0_i[k]), .m1(m1_i[k]),
        .scale(scale_s4_r), .llr_r(llr_w[2*k])
      );
      qlm_llr_unit u_llr_q (
        .clk(clk), .en(en), .used(used), .m0(m0_q[k]), .m1(m1_q[k]),
        .scale(scale_s4_r), .llr_r(llr_w[2*k+1])
      );
    end else begin : g_unused
      assign llr_w[2*k]   = '0;
      assign llr_w[2*k+1] = '0;
    end
  end

  assign out_data.llr_0 = llr_w[0];
  assign out_data.llr_1 = llr_w[1];
  assign out_data.llr_2 = llr_w[2];
  assign out_data.llr_3 = llr_w[3];
  assign out_data.llr_4 = llr_w[4];
  assign out_data.llr_5 = llr_w[5];
  assign out_data.llr_6 = llr_w[6];
  assign out_data.llr_7 = llr_w[7];

  // ---------------- assertions ----------------
  // accepted beat lands in stage 1
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted beat missing from stage 1");

  // input backs up only when every stage holds a beat
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("in_ready low with a bubble in the pipe");

  // a blocked mid-pipe beat is not dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && !rdy[3]) |=> vld_r[2])
    else $error("stalled beat lost in stage 3");

endmodule
